/* hw/rtl/rgb_to_hsv_pixel_assert.svh */
// assertion macros for the rgb to hsv pixel converter
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RHSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RHSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define RHSV_ASSERT(lbl, prop, msg)
`define RHSV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/rhsv_pkg.sv */
// shared types and constants of the rgb to hsv pixel converter
package rhsv_pkg;

    localparam int PIX_W       = 8;
    localparam int HUE_W       = 15;
    localparam int NUMER_W     = 11;
    localparam int DIV_W       = 9;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    localparam logic [2:0] BASE_RED_MIN   = 3'd3;
    localparam logic [2:0] BASE_GREEN_MIN = 3'd5;
    localparam logic [2:0] BASE_BLUE_MIN  = 3'd1;

    // 2 * 60 * 2^F equals 15 shifted left by F + 3
    localparam logic [3:0] HUE_SCALE_ODD  = 4'd15;
    localparam int         HUE_SCALE_SH   = 3;
    localparam logic [8:0] SAT_SCALE2     = 9'd510;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] value;
    } rhsv_ctl_t;

endpackage

/* hw/rtl/rgb_to_hsv_pixel.sv */
// top level of the rgb to hsv pixel converter
// Converts one 8-bit RGB pixel per clock into hue (1/2^HUE_FRAC_BITS degree),
// saturation (0..255) and value (max channel); hue and saturation are rounded
// to nearest. The block takes a new pixel every cycle while the output side
// keeps taking results. The path is one operand register, a chain of QW
// divider cells with QW = clog2(360 * 2^HUE_FRAC_BITS + 1), each settling
// one quotient bit of hue and of saturation, and the output register. While
// a result waits with m_tready low the whole chain holds and s_tready drops
// in the same cycle.
`include "rgb_to_hsv_pixel_assert.svh"

module rgb_to_hsv_pixel #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [rhsv_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hue [14:0], saturation [22:15], value [30:23], zero [31]
    output logic [rhsv_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int FULL_INT = 360 * (2 ** HUE_FRAC_BITS);
    localparam int QW       = $clog2(FULL_INT + 1);
    localparam int RW       = rhsv_pkg::DIV_W + QW;
    localparam logic [QW-1:0] FULL = QW'(FULL_INT);

    logic adv;

    rhsv_pkg::rhsv_ctl_t        ctl_s   [QW+1];
    logic [RW-1:0]              h_rem_s [QW+1];
    logic [rhsv_pkg::DIV_W-1:0] h_div_s [QW+1];
    logic [QW-1:0]              h_quo_s [QW+1];
    logic [RW-1:0]              s_rem_s [QW+1];
    logic [rhsv_pkg::DIV_W-1:0] s_div_s [QW+1];
    logic [QW-1:0]              s_quo_s [QW+1];

    logic [QW-1:0]               hue_wrap;
    logic                        out_valid_reg, out_valid_next;
    logic [rhsv_pkg::HUE_W-1:0]  hue_reg, hue_next;
    logic [rhsv_pkg::PIX_W-1:0]  sat_reg, sat_next;
    logic [rhsv_pkg::PIX_W-1:0]  val_reg, val_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    rhsv_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .RW            (RW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (s_tvalid),
        .red      (s_tdata[7:0]),
        .green    (s_tdata[15:8]),
        .blue     (s_tdata[23:16]),
        .ctl      (ctl_s[0]),
        .h_rem    (h_rem_s[0]),
        .h_div    (h_div_s[0]),
        .s_rem    (s_rem_s[0]),
        .s_div    (s_div_s[0])
    );

    assign h_quo_s[0] = '0;
    assign s_quo_s[0] = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        rhsv_div_cell #(
            .QW    (QW),
            .RW    (RW),
            .SHIFT (QW - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .ctl_in    (ctl_s[k]),
            .h_rem_in  (h_rem_s[k]),
            .h_div_in  (h_div_s[k]),
            .h_quo_in  (h_quo_s[k]),
            .s_rem_in  (s_rem_s[k]),
            .s_div_in  (s_div_s[k]),
            .s_quo_in  (s_quo_s[k]),
            .ctl_out   (ctl_s[k+1]),
            .h_rem_out (h_rem_s[k+1]),
            .h_div_out (h_div_s[k+1]),
            .h_quo_out (h_quo_s[k+1]),
            .s_rem_out (s_rem_s[k+1]),
            .s_div_out (s_div_s[k+1]),
            .s_quo_out (s_quo_s[k+1])
        );
    end

    always_comb
    begin
        // full circle wraps to zero
        hue_wrap       = (h_quo_s[QW] >= FULL) ? (h_quo_s[QW] - FULL) : h_quo_s[QW];
        out_valid_next = ctl_s[QW].valid;
        hue_next       = rhsv_pkg::HUE_W'(hue_wrap);
        sat_next       = rhsv_pkg::PIX_W'(s_quo_s[QW]);
        val_next       = ctl_s[QW].value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, val_reg, sat_reg, hue_reg};

    `RHSV_ASSERT(a_hue_range, ctl_s[QW].valid |-> (hue_wrap < FULL), "hue out of range")
    `RHSV_ASSERT(a_sat_width, ctl_s[QW].valid |-> (s_quo_s[QW][QW-1:8] == '0), "sat overflow")
    `RHSV_ASSERT(a_black_zero, (m_tvalid && (val_reg == '0)) |-> ((hue_reg == '0) && (sat_reg == '0)), "black not zero")
    `RHSV_ASSERT_NEXT(a_chain_hold, !adv, $stable(ctl_s[QW]), "chain moved during stall")

endmodule

/* hw/rtl/rhsv_front.sv */
// min/max, sector selection and divider operand setup
module rhsv_front #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int RW            = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [rhsv_pkg::PIX_W-1:0] red,
    input  logic [rhsv_pkg::PIX_W-1:0] green,
    input  logic [rhsv_pkg::PIX_W-1:0] blue,
    output rhsv_pkg::rhsv_ctl_t        ctl,
    output logic [RW-1:0]              h_rem,
    output logic [rhsv_pkg::DIV_W-1:0] h_div,
    output logic [RW-1:0]              s_rem,
    output logic [rhsv_pkg::DIV_W-1:0] s_div
);

    localparam int NH_SHIFT = HUE_FRAC_BITS + rhsv_pkg::HUE_SCALE_SH;

    logic [rhsv_pkg::PIX_W-1:0]   mn;
    logic [rhsv_pkg::PIX_W-1:0]   mx;
    logic [rhsv_pkg::PIX_W-1:0]   rng;
    logic [rhsv_pkg::PIX_W-1:0]   op_a;
    logic [rhsv_pkg::PIX_W-1:0]   op_b;
    logic [2:0]                   base;
    logic [rhsv_pkg::NUMER_W:0]   numer_w;
    logic [rhsv_pkg::NUMER_W-1:0] numer;
    logic [14:0]                  numer15;

    rhsv_pkg::rhsv_ctl_t        ctl_reg, ctl_next;
    logic [RW-1:0]              h_rem_reg, h_rem_next;
    logic [rhsv_pkg::DIV_W-1:0] h_div_reg, h_div_next;
    logic [RW-1:0]              s_rem_reg, s_rem_next;
    logic [rhsv_pkg::DIV_W-1:0] s_div_reg, s_div_next;

    always_comb
    begin
        mn = (red < green) ? red : green;
        mx = (red > green) ? red : green;
        mn = (blue < mn) ? blue : mn;
        mx = (blue > mx) ? blue : mx;
        rng = mx - mn;

        // first matching channel wins on ties
        if (red == mn)
        begin
            base = rhsv_pkg::BASE_RED_MIN;
            op_a = green;
            op_b = blue;
        end
        else if (green == mn)
        begin
            base = rhsv_pkg::BASE_GREEN_MIN;
            op_a = blue;
            op_b = red;
        end
        else
        begin
            base = rhsv_pkg::BASE_BLUE_MIN;
            op_a = red;
            op_b = green;
        end

        numer_w = (12'(base) * 12'(rng)) + 12'(op_b) - 12'(op_a);
        numer   = numer_w[rhsv_pkg::NUMER_W-1:0];
        numer15 = 15'(numer) * 15'(rhsv_pkg::HUE_SCALE_ODD);

        ctl_next.valid = in_valid;
        ctl_next.value = mx;

        if (mn == mx)
        begin
            // gray pixel: zero over one gives zero hue and saturation
            h_rem_next = '0;
            h_div_next = rhsv_pkg::DIV_W'(1);
            s_rem_next = '0;
            s_div_next = rhsv_pkg::DIV_W'(1);
        end
        else
        begin
            h_rem_next = (RW'(numer15) << NH_SHIFT) + RW'(rng);
            h_div_next = {rng, 1'b0};
            s_rem_next = (RW'(rng) * RW'(rhsv_pkg::SAT_SCALE2)) + RW'(mx);
            s_div_next = {mx, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_rem_reg <= h_rem_next;
            h_div_reg <= h_div_next;
            s_rem_reg <= s_rem_next;
            s_div_reg <= s_div_next;
        end
    end

    assign ctl   = ctl_reg;
    assign h_rem = h_rem_reg;
    assign h_div = h_div_reg;
    assign s_rem = s_rem_reg;
    assign s_div = s_div_reg;

endmodule

/* hw/rtl/rhsv_div_cell.sv */
// one restoring divider cell: one quotient bit each for hue and saturation
module rhsv_div_cell #(
    parameter int QW    = 15,
    parameter int RW    = 24,
    parameter int SHIFT = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  rhsv_pkg::rhsv_ctl_t        ctl_in,
    input  logic [RW-1:0]              h_rem_in,
    input  logic [rhsv_pkg::DIV_W-1:0] h_div_in,
    input  logic [QW-1:0]              h_quo_in,
    input  logic [RW-1:0]              s_rem_in,
    input  logic [rhsv_pkg::DIV_W-1:0] s_div_in,
    input  logic [QW-1:0]              s_quo_in,
    output rhsv_pkg::rhsv_ctl_t        ctl_out,
    output logic [RW-1:0]              h_rem_out,
    output logic [rhsv_pkg::DIV_W-1:0] h_div_out,
    output logic [QW-1:0]              h_quo_out,
    output logic [RW-1:0]              s_rem_out,
    output logic [rhsv_pkg::DIV_W-1:0] s_div_out,
    output logic [QW-1:0]              s_quo_out
);

    logic [RW-1:0] h_sh;
    logic [RW-1:0] s_sh;
    logic          h_ge;
    logic          s_ge;

    rhsv_pkg::rhsv_ctl_t        ctl_reg;
    logic [RW-1:0]              h_rem_reg, h_rem_next;
    logic [rhsv_pkg::DIV_W-1:0] h_div_reg;
    logic [QW-1:0]              h_quo_reg, h_quo_next;
    logic [RW-1:0]              s_rem_reg, s_rem_next;
    logic [rhsv_pkg::DIV_W-1:0] s_div_reg;
    logic [QW-1:0]              s_quo_reg, s_quo_next;

    always_comb
    begin
        h_sh = RW'(h_div_in) << SHIFT;
        s_sh = RW'(s_div_in) << SHIFT;
        h_ge = (h_rem_in >= h_sh);
        s_ge = (s_rem_in >= s_sh);
        h_rem_next = h_ge ? (h_rem_in - h_sh) : h_rem_in;
        s_rem_next = s_ge ? (s_rem_in - s_sh) : s_rem_in;
        h_quo_next = h_quo_in | (QW'(h_ge) << SHIFT);
        s_quo_next = s_quo_in | (QW'(s_ge) << SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_rem_reg <= h_rem_next;
            h_div_reg <= h_div_in;
            h_quo_reg <= h_quo_next;
            s_rem_reg <= s_rem_next;
            s_div_reg <= s_div_in;
            s_quo_reg <= s_quo_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign h_rem_out = h_rem_reg;
    assign h_div_out = h_div_reg;
    assign h_quo_out = h_quo_reg;
    assign s_rem_out = s_rem_reg;
    assign s_div_out = s_div_reg;
    assign s_quo_out = s_quo_reg;

endmodule

/* bench/rgb_to_hsv_pixel_tb.sv */
// self-checking testbench for the rgb to hsv pixel converter
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_tb;

    localparam int     HUE_FRAC_BITS = 6;
    localparam int     LATENCY       = $clog2(360 * (1 << HUE_FRAC_BITS) + 1) + 2;
    localparam longint HUE_SCALE     = 60 << HUE_FRAC_BITS;
    localparam longint HUE_FULL      = 360 << HUE_FRAC_BITS;
    localparam longint SAT_FULL      = 255;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     REPORT_MAX    = 10;

    typedef struct packed {
        logic [rhsv_pkg::PIX_W-1:0] blue;
        logic [rhsv_pkg::PIX_W-1:0] green;
        logic [rhsv_pkg::PIX_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic                       zero;
        logic [rhsv_pkg::PIX_W-1:0] value;
        logic [rhsv_pkg::PIX_W-1:0] saturation;
        logic [rhsv_pkg::HUE_W-1:0] hue;
    } hsv_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rhsv_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rhsv_pkg::M_TDATA_W-1:0] m_tdata;

    hsv_t expected_hsv[$];
    int   errors      = 0;
    int   cycle_count = 0;
    bit   tx_idle_en  = 1'b1;
    bit   rx_idle_en  = 1'b1;
    int   hold_request = 0;

    rgb_to_hsv_pixel #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic hsv_t predict_hsv(input rgb_t px);
        hsv_t       res;
        longint     r;
        longint     g;
        longint     b;
        longint     lo;
        longint     hi;
        longint     d;
        longint     diff;
        longint     numer;
        longint     h;
        longint     sat;
        logic [2:0] base;
        r = px.red;
        g = px.green;
        b = px.blue;
        lo = (r < g) ? r : g;
        hi = (r > g) ? r : g;
        lo = (b < lo) ? b : lo;
        hi = (b > hi) ? b : hi;
        res = '0;
        res.value = hi[rhsv_pkg::PIX_W-1:0];
        if (lo != hi)
        begin
            d = hi - lo;
            if (r == lo)
            begin
                base = rhsv_pkg::BASE_RED_MIN;
                diff = g - b;
            end
            else if (g == lo)
            begin
                base = rhsv_pkg::BASE_GREEN_MIN;
                diff = b - r;
            end
            else
            begin
                base = rhsv_pkg::BASE_BLUE_MIN;
                diff = r - g;
            end
            numer = longint'(base) * d - diff;
            h = (2 * numer * HUE_SCALE + d) / (2 * d);
            while (h >= HUE_FULL)
                h = h - HUE_FULL;
            res.hue = h[rhsv_pkg::HUE_W-1:0];
            sat = (2 * d * SAT_FULL + hi) / (2 * hi);
            res.saturation = sat[rhsv_pkg::PIX_W-1:0];
        end
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // random pixel: plain, gray, tied minimum or maximum, or channel extremes
    function automatic rgb_t rand_pixel();
        rgb_t px;
        int   roll;
        roll = $urandom_range(0, 99);
        px = rgb_t'(24'($urandom));
        if (roll < 12)
        begin
            px.green = px.red;
            px.blue  = px.red;
        end
        else if (roll < 27)
        begin
            case ($urandom_range(0, 2))
                0: px.green = px.red;
                1: px.blue  = px.red;
                default: px.blue = px.green;
            endcase
        end
        else if (roll < 37)
        begin
            px.red   = {{7{px.red[7]}},   px.red[0]};
            px.green = {{7{px.green[7]}}, px.green[0]};
            px.blue  = {{7{px.blue[7]}},  px.blue[0]};
        end
        return px;
    endfunction

    task automatic send_pixel(input rgb_t px);
        int gap;
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_hsv.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // hue and saturation forced to zero when all channels match
    task automatic test_gray_pixels();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        // {blue, green, red}
        send_pixel({8'd0,   8'd0,   8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd128, 8'd128, 8'd128});
        send_pixel({8'd1,   8'd1,   8'd1});
        wait_drained();
    endtask

    task automatic test_hue_sectors();
        send_pixel({8'd128, 8'd255, 8'd0});
        send_pixel({8'd128, 8'd0,   8'd255});
        send_pixel({8'd0,   8'd128, 8'd255});
        send_pixel({8'd50,  8'd200, 8'd10});
        send_pixel({8'd3,   8'd90,  8'd250});
        send_pixel({8'd240, 8'd7,   8'd100});
        wait_drained();
    endtask

    // ties on the minimum, and pure red wrapping from 360 to 0
    task automatic test_min_ties();
        send_pixel({8'd255, 8'd0,   8'd0});
        send_pixel({8'd0,   8'd255, 8'd0});
        send_pixel({8'd0,   8'd0,   8'd255});
        send_pixel({8'd0,   8'd0,   8'd200});
        send_pixel({8'd77,  8'd200, 8'd77});
        wait_drained();
    endtask

    // saturation halves round up, smallest nonzero ranges
    task automatic test_rounding();
        send_pixel({8'd1,   8'd1,   8'd2});
        send_pixel({8'd254, 8'd255, 8'd255});
        send_pixel({8'd0,   8'd0,   8'd1});
        send_pixel({8'd0,   8'd1,   8'd0});
        send_pixel({8'd255, 8'd254, 8'd255});
        wait_drained();
    endtask

    task automatic test_random_stream(input int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) send_pixel(rand_pixel());
        wait_drained();
    endtask

    task automatic test_steady_stream(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_pixel(rand_pixel());
        wait_drained();
    endtask

    task automatic test_backpressure(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        hold_request = 150;
        repeat (count) send_pixel(rand_pixel());
        wait_drained();
    endtask

    initial
    begin
        int wait_left;
        wait_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                wait_left = hold_request;
                hold_request = 0;
            end
            if (wait_left > 0)
            begin
                m_tready <= 1'b0;
                wait_left--;
            end
            else if (rx_idle_en)
            begin
                wait_left = pick_gap();
                m_tready <= (wait_left == 0);
                if (wait_left > 0)
                    wait_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        hsv_t got;
        hsv_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_hsv.push_back(predict_hsv(rgb_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                got = hsv_t'(m_tdata);
                if (expected_hsv.size() == 0)
                begin
                    if (errors < REPORT_MAX)
                        $display("unexpected result h=%0d s=%0d v=%0d",
                                 got.hue, got.saturation, got.value);
                    errors++;
                end
                else
                begin
                    want = expected_hsv.pop_front();
                    if (got !== want)
                    begin
                        if (errors < REPORT_MAX)
                            $display("mismatch: expected h=%0d s=%0d v=%0d z=%0b, got h=%0d s=%0d v=%0d z=%0b",
                                     want.hue, want.saturation, want.value, want.zero,
                                     got.hue, got.saturation, got.value, got.zero);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_gray_pixels();
        test_hue_sectors();
        test_min_ties();
        test_rounding();
        test_random_stream(370);
        test_steady_stream(40);
        test_backpressure(40);
        if (errors == 0 && expected_hsv.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
